// ----- sv/ptc_pkg.sv -----
package ptc_pkg;

  localparam int unsigned RawW  = 20;
  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned CfgW  = 64;

  typedef enum logic [IdxW-1:0] {
    REG_TEMP_CAL  = 2'd0,
    REG_PRESS_LO  = 2'd1,
    REG_PRESS_HI  = 2'd2,
    REG_PRESS_P9  = 2'd3
  } reg_idx_e;

  localparam logic [WordW-1:0] PressOffset = 32'd64000;
  localparam logic [WordW-1:0] PressFull   = 32'd1048576;
  localparam logic [WordW-1:0] PressScale  = 32'd3125;
  localparam logic [WordW-1:0] HalfRange   = 32'h8000_0000;
  localparam logic [WordW-1:0] DivBias     = 32'd32768;
  localparam logic [WordW-1:0] TempRound   = 32'd128;

  typedef struct packed {
    logic [15:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [15:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
  } coef_t;

  // Wrapping 32-bit multiply.
  function automatic logic [WordW-1:0] mul32(input logic [WordW-1:0] x,
                                             input logic [WordW-1:0] y);
    logic [2*WordW-1:0] full;
    full = x * y;
    return full[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] sar(input logic [WordW-1:0] x,
                                           input int unsigned n);
    return WordW'($signed(x) >>> n);
  endfunction

endpackage

// ----- sv/ptc_cfg.sv -----
module ptc_cfg
  import ptc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output coef_t           coef_o
);

  logic [47:0] tcal_q;
  logic [63:0] plo_q, phi_q;
  logic [15:0] p9_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q <= '0;
      plo_q  <= '0;
      phi_q  <= '0;
      p9_q   <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_e'(cfg_index_i))
        REG_TEMP_CAL: tcal_q <= cfg_data_i[47:0];
        REG_PRESS_LO: plo_q  <= cfg_data_i;
        REG_PRESS_HI: phi_q  <= cfg_data_i;
        REG_PRESS_P9: p9_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef_o.t1 = tcal_q[15:0];
    coef_o.t2 = {{16{tcal_q[31]}}, tcal_q[31:16]};
    coef_o.t3 = {{16{tcal_q[47]}}, tcal_q[47:32]};
    coef_o.p1 = plo_q[15:0];
    coef_o.p2 = {{16{plo_q[31]}}, plo_q[31:16]};
    coef_o.p3 = {{16{plo_q[47]}}, plo_q[47:32]};
    coef_o.p4 = {{16{plo_q[63]}}, plo_q[63:48]};
    coef_o.p5 = {{16{phi_q[15]}}, phi_q[15:0]};
    coef_o.p6 = {{16{phi_q[31]}}, phi_q[31:16]};
    coef_o.p7 = {{16{phi_q[47]}}, phi_q[47:32]};
    coef_o.p8 = {{16{phi_q[63]}}, phi_q[63:48]};
    coef_o.p9 = {{16{p9_q[15]}}, p9_q};
  end

endmodule

// ----- sv/ptc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; carries side data.
module ptc_div
  import ptc_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [WordW-1:0] num_i,
  input  logic [WordW-1:0] den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [WordW-1:0] quo_o,
  output logic [SideW-1:0] side_o
);

  logic [WordW-1:0] num_q [WordW+1];
  logic [WordW:0]   rem_q [WordW+1];
  logic [WordW-1:0] den_q [WordW+1];
  logic [SideW-1:0] side_q [WordW+1];
  logic             vld_q [WordW+1];

  always_comb begin
    num_q[0]  = num_i;
    rem_q[0]  = '0;
    den_q[0]  = den_i;
    side_q[0] = side_i;
    vld_q[0]  = valid_i;
  end

  for (genvar s = 0; s < WordW; s++) begin : g_stage
    logic [WordW:0]   sh;
    logic [WordW+1:0] df;
    assign sh = {rem_q[s][WordW-1:0], num_q[s][WordW-1]};
    assign df = {1'b0, sh} - {2'b00, den_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
        if (!df[WordW+1]) begin
          rem_q[s+1] <= df[WordW:0];
          num_q[s+1] <= {num_q[s][WordW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= sh;
          num_q[s+1] <= {num_q[s][WordW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[WordW];
  assign quo_o   = num_q[WordW];
  assign side_o  = side_q[WordW];

endmodule

// ----- sv/pressure_temp_compensation.sv -----
// Integer barometric compensation engine. One reading pair enters per clock
// unless the output is stalled, through 13 arithmetic stages and a 32-stage
// one-bit-per-stage divider; the whole pipeline freezes while the output is
// stalled. The user must write calibration words through the config port
// (always ready) only while the engine is empty; the block does not check it.
module pressure_temp_compensation
  import ptc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [RawW-1:0]         raw_temperature_i,
  input  logic [RawW-1:0]         raw_pressure_i,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WordW-1:0] temperature_centi_o,
  output logic signed [WordW-1:0] fine_temperature_o,
  output logic [WordW-1:0]        pressure_pascal_o,
  output logic                    pressure_invalid_o,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IdxW-1:0]         cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i
);

  coef_t c;
  logic  en;

  ptc_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .coef_o(c)
  );

  // Whole pipe advances unless the output register holds an untaken result.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  localparam int unsigned NS = 11;
  logic [NS:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[NS-1:1], in_valid};
  end

  // s1
  logic [WordW-1:0] rp1_q, ta1_q, d1_q;
  // s2
  logic [WordW-1:0] rp2_q, a2_q, dd2_q;
  // s3
  logic [WordW-1:0] rp3_q, a3_q, b3_q;
  // s4
  logic [WordW-1:0] rp4_q, fine4_q;
  // s5
  logic [WordW-1:0] rp5_q, fine5_q, f5x_q, pa5_q;
  // s6
  logic [WordW-1:0] rp6_q, fine6_q, tc6_q, pa6_q, sq6_q, ap5_q, ap2_q;
  // s7
  logic [WordW-1:0] rp7_q, fine7_q, tc7_q, b7_q, x7_q, y7_q;
  // s8
  logic [WordW-1:0] rp8_q, fine8_q, tc8_q, b8_q, a8_q;
  // s9
  logic [WordW-1:0] rp9_q, fine9_q, tc9_q, b9_q, dv9_q;
  // s10
  logic [WordW-1:0] fine10_q, tc10_q, dv10_q, praw10_q;
  // s11
  logic [WordW-1:0] fine11_q, tc11_q, dv11_q, pr11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rp1_q <= WordW'(raw_pressure_i);
      ta1_q <= WordW'(raw_temperature_i >> 3) - {15'd0, c.t1, 1'b0};
      d1_q  <= WordW'(raw_temperature_i >> 4) - {16'd0, c.t1};

      rp2_q <= rp1_q;
      a2_q  <= sar(mul32(ta1_q, c.t2), 11);
      dd2_q <= mul32(d1_q, d1_q);

      rp3_q <= rp2_q;
      a3_q  <= a2_q;
      b3_q  <= mul32(sar(dd2_q, 12), c.t3);

      rp4_q   <= rp3_q;
      fine4_q <= a3_q + sar(b3_q, 14);

      rp5_q   <= rp4_q;
      fine5_q <= fine4_q;
      f5x_q   <= mul32(fine4_q, 32'd5) + TempRound;
      pa5_q   <= sar(fine4_q, 1) - PressOffset;

      rp6_q   <= rp5_q;
      fine6_q <= fine5_q;
      tc6_q   <= sar(f5x_q, 8);
      pa6_q   <= pa5_q;
      sq6_q   <= mul32(sar(pa5_q, 2), sar(pa5_q, 2));
      ap5_q   <= mul32(pa5_q, c.p5);
      ap2_q   <= mul32(c.p2, pa5_q);

      rp7_q   <= rp6_q;
      fine7_q <= fine6_q;
      tc7_q   <= tc6_q;
      b7_q    <= mul32(sar(sq6_q, 11), c.p6) + {ap5_q[WordW-2:0], 1'b0};
      x7_q    <= mul32(c.p3, sar(sq6_q, 13));
      y7_q    <= sar(ap2_q, 1);

      rp8_q   <= rp7_q;
      fine8_q <= fine7_q;
      tc8_q   <= tc7_q;
      b8_q    <= sar(b7_q, 2) + {c.p4[15:0], 16'd0};
      a8_q    <= sar(sar(x7_q, 3) + y7_q, 18);

      rp9_q   <= rp8_q;
      fine9_q <= fine8_q;
      tc9_q   <= tc8_q;
      b9_q    <= b8_q;
      dv9_q   <= sar(mul32(DivBias + a8_q, {16'd0, c.p1}), 15);

      fine10_q <= fine9_q;
      tc10_q   <= tc9_q;
      dv10_q   <= dv9_q;
      praw10_q <= (PressFull - rp9_q) - sar(b9_q, 12);

      fine11_q <= fine10_q;
      tc11_q   <= tc10_q;
      dv11_q   <= dv10_q;
      pr11_q   <= mul32(praw10_q, PressScale);
    end
  end

  // stage 12: numerator select into divider
  logic             big;
  logic [WordW-1:0] num;
  assign big = pr11_q >= HalfRange;
  assign num = big ? pr11_q : {pr11_q[WordW-2:0], 1'b0};

  localparam int unsigned SideW = 2*WordW + 2;
  logic             dvo_v;
  logic [WordW-1:0] quo;
  logic [SideW-1:0] side_o;
  logic             d_big, d_zero;
  logic [WordW-1:0] d_tc, d_fine;

  ptc_div #(.SideW(SideW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_q[11]),
    .num_i(num), .den_i(dv11_q),
    .side_i({tc11_q, fine11_q, big, (dv11_q == '0)}),
    .valid_o(dvo_v), .quo_o(quo), .side_o(side_o)
  );
  assign {d_tc, d_fine, d_big, d_zero} = side_o;

  // post stages: correction terms
  logic [WordW-1:0] p_a, ps_q, tca_q, fna_q, sq_q, p8m_q;
  logic             va_q, za_q;
  assign p_a = d_big ? {quo[WordW-2:0], 1'b0} : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va_q      <= dvo_v;
      out_valid <= va_q;
    end
  end

  logic [WordW-1:0] p3s;
  assign p3s = p_a >> 3;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q  <= p_a;
      tca_q <= d_tc;
      fna_q <= d_fine;
      za_q  <= d_zero;
      sq_q  <= mul32(p3s, p3s) >> 13;
      p8m_q <= sar(mul32(p_a >> 2, c.p8), 13);
    end
  end

  logic [WordW-1:0] ca;
  assign ca = sar(mul32(c.p9, sq_q), 12);

  always_ff @(posedge clk_i) begin
    if (en) begin
      temperature_centi_o <= tca_q;
      fine_temperature_o  <= fna_q;
      pressure_invalid_o  <= za_q;
      pressure_pascal_o   <= za_q ? '0 : ps_q + sar(ca + p8m_q + c.p7, 4);
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(pressure_pascal_o))
    else $error("result changed while stalled");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && pressure_invalid_o |-> pressure_pascal_o == '0)
    else $error("invalid pressure not zero");
`endif

endmodule
